// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every rising clock edge outside reset.
`define SRR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion %m failed");

// Same-cycle implication.
`define SRR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion %m failed");

// Next-cycle implication.
`define SRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion %m failed");

`endif

// ----- rtl/core/srr_pkg.sv -----
package srr_pkg;

    // Default configuration
    localparam int unsigned WINDOW_DEF       = 8;
    localparam int unsigned SLOTS_DEF        = 8;
    localparam int unsigned SEQ_BITS_DEF     = 16;
    localparam int unsigned PAYLOAD_BITS_DEF = 32;

    // Stream field widths
    localparam int unsigned SEQ_FIELD_W = 16;
    localparam int unsigned PAY_FIELD_W = 32;
    localparam int unsigned S_TDATA_W   = 48;
    localparam int unsigned M_TDATA_W   = 48;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef enum logic {
        KIND_DELIVER = 1'b0,
        KIND_ACK     = 1'b1
    } t_kind;

endpackage

// ----- rtl/core/srr_slot_mem.sv -----
module srr_slot_mem #(
    parameter int unsigned DEPTH  = srr_pkg::SLOTS_DEF,
    parameter int unsigned DATA_W = srr_pkg::PAYLOAD_BITS_DEF,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);
    import srr_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, new data forwarded on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/selective_repeat_receiver.sv -----
// Selective-repeat ARQ receiver.
// Slave stream: one arriving packet per transfer. tuser carries the checksum-good
// flag, tdata the sequence number and one payload word. Master stream: results,
// tuser = 0 for an in-order payload delivered upward, 1 for an acknowledgement;
// tlast marks the final result of a packet (always the acknowledgement).
// Bad-checksum packets and packets outside both the current and the previous
// window are dropped and give no result.
// Sequence: a packet is taken, then each of its D released payloads (0..WINDOW)
// is delivered in order and the acknowledgement comes last. One packet is in work
// at a time; tready returns as the acknowledgement is loaded into the output
// register. The sweep runs at one slot per cycle while the output register is free,
// set by the single read port of the payload memory. After the accepting edge the
// receiver enters its scan state, from which the first result is registered.
// A single output register decouples the master side: a finished result waits
// there while the next packet is taken; a stalled master holds the sweep.
// Reset (synchronous, active low) zeroes the window base and clears all slot
// valid bits at once; no clearing pass. Payload memory is not reset.
module selective_repeat_receiver #(
    parameter int unsigned WINDOW       = srr_pkg::WINDOW_DEF,
    parameter int unsigned SLOTS        = srr_pkg::SLOTS_DEF,
    parameter int unsigned SEQ_BITS     = srr_pkg::SEQ_BITS_DEF,
    parameter int unsigned PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [srr_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // seq_num, payload_word
    input  logic                          i_s_axis_tuser,  // checksum_ok
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [srr_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // delivered_payload, ack_num
    output logic                          o_m_axis_tuser,  // result_kind
    output logic                          o_m_axis_tlast   // last
);
    import srr_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W     = $clog2(WINDOW + 1);
    localparam int unsigned TAB_DEPTH = 128;
    localparam int unsigned TAB_W     = 7;

    // Residue table: small index value -> slot number
    typedef logic [TAB_DEPTH-1:0][SLOT_W-1:0] t_mod_tab;

    function automatic t_mod_tab f_mod_tab();
        t_mod_tab tab;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            tab[i] = SLOT_W'(i % SLOTS);
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = f_mod_tab();

    t_state                  r_state, n_state;
    logic [SEQ_BITS-1:0]     r_base, n_base;
    logic [SLOT_W-1:0]       r_bs, n_bs;
    logic [SLOTS-1:0]        r_valid, n_valid;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [SEQ_BITS-1:0]     r_ack_seq, n_ack_seq;
    logic                    r_out_valid, n_out_valid;
    t_kind                   r_out_kind, n_out_kind;
    logic                    r_out_last, n_out_last;
    logic [PAY_FIELD_W-1:0]  r_out_pay, n_out_pay;
    logic [SEQ_FIELD_W-1:0]  r_out_ack, n_out_ack;

    logic [63:0]             w_seq_in_wide;
    logic [63:0]             w_seq_wide;
    logic [63:0]             w_pay_wide;
    logic [63:0]             w_ahead_wide;
    logic [63:0]             w_rd_wide;
    logic [63:0]             w_ack_wide;
    logic [SEQ_BITS-1:0]     w_seq;
    logic [SEQ_BITS-1:0]     w_ahead;
    logic [SEQ_BITS-1:0]     w_behind;
    logic [PAYLOAD_BITS-1:0] w_pay;
    logic [PAYLOAD_BITS-1:0] w_rd_data;
    logic                    w_current;
    logic                    w_previous;
    logic                    w_wrap;
    logic [TAB_W-1:0]        w_tab_idx;
    logic [SLOT_W-1:0]       w_wr_slot;
    logic                    w_accept;
    logic                    w_take;
    logic                    w_store;
    logic                    w_out_free;
    logic                    w_can_deliver;
    logic                    w_deliver;
    logic                    w_ack;
    logic                    w_base_max;

    // Payload buffer
    srr_slot_mem #(
        .DEPTH  (SLOTS),
        .DATA_W (PAYLOAD_BITS)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (w_wr_slot),
        .i_wr_data (w_pay),
        .i_rd_addr (n_bs),
        .o_rd_data (w_rd_data)
    );

    // Input field unpacking
    assign w_seq_in_wide = 64'(i_s_axis_tdata[SEQ_FIELD_W-1:0]);
    assign w_seq         = w_seq_in_wide[SEQ_BITS-1:0];
    assign w_seq_wide    = 64'(w_seq);
    assign w_pay_wide    = 64'(i_s_axis_tdata[SEQ_FIELD_W +: PAY_FIELD_W]);
    assign w_pay         = w_pay_wide[PAYLOAD_BITS-1:0];

    // Window classification, serial distance against the base
    assign w_ahead    = w_seq - r_base;
    assign w_behind   = r_base - w_seq;
    assign w_current  = w_ahead < SEQ_BITS'(WINDOW);
    assign w_previous = (w_behind != '0) && (w_behind <= SEQ_BITS'(WINDOW));

    // Slot of the arriving packet: base slot plus distance, or the small
    // wrapped sequence number itself when the window crosses zero
    assign w_wrap       = w_seq < r_base;
    assign w_ahead_wide = 64'(w_ahead);
    assign w_tab_idx    = w_wrap ? w_seq_wide[TAB_W-1:0]
                                 : (TAB_W'(r_bs) + TAB_W'(w_ahead_wide[5:0]));
    assign w_wr_slot    = MOD_TAB[w_tab_idx];

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_take   = w_accept && i_s_axis_tuser && (w_current || w_previous);
    assign w_store  = w_accept && i_s_axis_tuser && w_current;

    // Sweep control
    assign w_out_free    = !r_out_valid || i_m_axis_tready;
    assign w_can_deliver = r_valid[r_bs] && (r_cnt < CNT_W'(WINDOW));
    assign w_deliver     = (r_state == ST_SCAN) && w_can_deliver && w_out_free;
    assign w_ack         = (r_state == ST_SCAN) && !w_can_deliver && w_out_free;
    assign w_base_max    = (r_base == '1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_SCAN: o_s_axis_tready = 1'b0;
            default: o_s_axis_tready = 1'b0;
        endcase
    end

    // Window state update
    always_comb begin
        n_base    = r_base;
        n_bs      = r_bs;
        n_valid   = r_valid;
        n_cnt     = r_cnt;
        n_ack_seq = r_ack_seq;
        if (w_store) begin
            n_valid[w_wr_slot] = 1'b1;
        end
        if (w_accept) begin
            n_ack_seq = w_seq;
            // previous-window packet: counter starts saturated, no sweep
            n_cnt     = w_current ? '0 : CNT_W'(WINDOW);
        end
        if (w_deliver) begin
            n_valid[r_bs] = 1'b0;
            n_base        = r_base + SEQ_BITS'(1);
            n_bs          = (w_base_max || (r_bs == SLOT_W'(SLOTS - 1)))
                            ? '0 : (r_bs + SLOT_W'(1));
            n_cnt         = r_cnt + CNT_W'(1);
        end
    end

    // Result register
    assign w_rd_wide  = 64'(w_rd_data);
    assign w_ack_wide = 64'(r_ack_seq);

    always_comb begin
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        n_out_pay   = r_out_pay;
        n_out_ack   = r_out_ack;
        if (w_deliver) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_DELIVER;
            n_out_last  = 1'b0;
            n_out_pay   = w_rd_wide[PAY_FIELD_W-1:0];
            n_out_ack   = '0;
        end else if (w_ack) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_ACK;
            n_out_last  = 1'b1;
            n_out_pay   = '0;
            n_out_ack   = w_ack_wide[SEQ_FIELD_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= '0;
            r_bs        <= '0;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_bs        <= n_bs;
            r_valid     <= n_valid;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        r_ack_seq  <= n_ack_seq;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
        r_out_pay  <= n_out_pay;
        r_out_ack  <= n_out_ack;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_ack, r_out_pay};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // Checks
    `SRR_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(WINDOW))
    `SRR_ASSERT_IMPL(a_base_moves_on_delivery, i_clk, i_rst_n, !$stable(r_base), $past(w_deliver))
    `SRR_ASSERT_NEXT(a_delivered_slot_freed, i_clk, i_rst_n, w_deliver, !r_valid[$past(r_bs)])

endmodule

// ----- tb/selective_repeat_receiver_test.sv -----
`timescale 1ns / 1ps

module selective_repeat_receiver_test;
    import srr_pkg::*;

    localparam int unsigned WINDOW       = WINDOW_DEF;
    localparam int unsigned SLOTS        = SLOTS_DEF;
    localparam int unsigned SEQ_BITS     = SEQ_BITS_DEF;
    localparam int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF;
    localparam int unsigned RANDOM_PACKETS = 200;
    localparam int unsigned IDLE_PCT       = 31;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned DIRECTED_ROWS  = 22;

    // How a directed row is checked
    typedef enum {
        CHK_MODEL,
        CHK_DROP,
        CHK_ACK
    } t_row_check;

    typedef struct {
        bit              ok;
        logic [15:0]     seq;
        logic [31:0]     pay;
        t_row_check      chk;
    } t_stim_row;

    typedef struct {
        t_kind       kind;
        logic [31:0] word;
        logic [15:0] ack_num;
        logic        last;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;   // seq_num, payload_word
    logic                  i_s_axis_tuser;   // checksum_ok
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;   // delivered_payload, ack_num
    logic                  o_m_axis_tuser;   // result_kind
    logic                  o_m_axis_tlast;   // last

    // Predictor state
    logic [SEQ_BITS-1:0]     window_base;
    bit                      slot_full [SLOTS];
    logic [PAYLOAD_BITS-1:0] slot_word [SLOTS];

    t_result     due_results [$];
    int          mismatches = 0;
    int          idle_pct = IDLE_PCT;
    int unsigned cycle_count = 0;
    t_stim_row   directed_rows [DIRECTED_ROWS];

    selective_repeat_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Downstream stall pattern
    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(99) >= idle_pct);
    end

    // Result checker: each transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0b tdata %h last %0b",
                       o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (o_m_axis_tuser !== want.kind) begin
                    $error("result_kind: expected %0b, got %0b", want.kind, o_m_axis_tuser);
                    mismatches++;
                end
                if (o_m_axis_tdata[31:0] !== want.word) begin
                    $error("delivered_payload: expected %h, got %h",
                           want.word, o_m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (o_m_axis_tdata[47:32] !== want.ack_num) begin
                    $error("ack_num: expected %h, got %h",
                           want.ack_num, o_m_axis_tdata[47:32]);
                    mismatches++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Receiver behavior for one arriving packet; updates the window state
    function automatic void absorb_packet(input bit ok, input logic [15:0] seq,
                                          input logic [31:0] pay, ref t_result outs[$]);
        logic [SEQ_BITS-1:0] s;
        logic [SEQ_BITS-1:0] ahead;
        logic [SEQ_BITS-1:0] behind;
        bit                  in_cur;
        bit                  in_prev;
        int                  idx;
        int                  b;
        outs.delete();
        if (!ok)
            return;
        s       = seq[SEQ_BITS-1:0];
        ahead   = s - window_base;
        behind  = window_base - s;
        in_cur  = (ahead < WINDOW);
        in_prev = (behind >= 1) && (behind <= WINDOW);
        if (!in_cur && !in_prev)
            return;
        if (in_cur) begin
            idx = int'(s % SLOTS);
            slot_word[idx] = pay[PAYLOAD_BITS-1:0];
            slot_full[idx] = 1'b1;
            // in-order release from the window base
            for (int n = 0; n < WINDOW; n++) begin
                b = int'(window_base % SLOTS);
                if (!slot_full[b])
                    break;
                outs.push_back('{KIND_DELIVER, 32'(slot_word[b]), 16'h0, 1'b0});
                slot_full[b] = 1'b0;
                window_base  = window_base + 1'b1;
            end
        end
        outs.push_back('{KIND_ACK, 32'h0, 16'(s), 1'b1});
    endfunction

    // Offer one packet upstream; called right after a falling edge
    task automatic offer_packet(input bit ok, input logic [15:0] seq,
                                input logic [31:0] pay, input t_row_check chk);
        t_result outs [$];
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = ok;
        i_s_axis_tdata  = {pay, seq};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        absorb_packet(ok, seq, pay, outs);
        case (chk)
            CHK_MODEL: begin
                foreach (outs[i])
                    due_results.push_back(outs[i]);
            end
            CHK_ACK: begin
                due_results.push_back('{KIND_ACK, 32'h0, seq, 1'b1});
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] seq;
        int unsigned pick;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        window_base     = '0;
        foreach (slot_full[i]) begin
            slot_full[i] = 1'b0;
            slot_word[i] = '0;
        end

        // Directed rows, starting from base 0
        directed_rows = '{
            '{1'b0, 16'h0000, 32'hFFFF_FFFF, CHK_DROP},   // bad checksum
            '{1'b1, 16'h8000, 32'h0000_0000, CHK_DROP},   // far outside both windows
            '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, CHK_ACK},    // previous window, one behind
            '{1'b1, 16'hFFF8, 32'h0000_0000, CHK_ACK},    // previous window, full depth
            '{1'b1, 16'hFFF7, 32'h0000_0000, CHK_DROP},   // just past previous window
            '{1'b1, 16'h0008, 32'h0000_0000, CHK_DROP},   // just past current window
            '{1'b1, 16'h0007, 32'hFFFF_FFFF, CHK_ACK},    // top of window, buffered
            '{1'b1, 16'h0003, 32'h0000_0000, CHK_ACK},
            '{1'b1, 16'h0003, 32'hA5A5_A5A5, CHK_ACK},    // duplicate overwrites slot
            '{1'b1, 16'h0001, 32'h0000_0001, CHK_ACK},
            '{1'b1, 16'h0002, 32'h8000_0000, CHK_ACK},
            '{1'b1, 16'h0004, 32'h5A5A_5A5A, CHK_ACK},
            '{1'b1, 16'h0005, 32'h0000_FFFF, CHK_ACK},
            '{1'b1, 16'h0006, 32'hFFFF_0000, CHK_ACK},
            '{1'b0, 16'h0000, 32'h1234_5678, CHK_DROP},   // bad checksum on base slot
            '{1'b1, 16'h0000, 32'h0000_0000, CHK_MODEL},  // full-window burst
            '{1'b1, 16'h0007, 32'h0BAD_0BAD, CHK_ACK},    // old window after advance
            '{1'b1, 16'h0000, 32'h0BAD_0BAD, CHK_ACK},
            '{1'b1, 16'hFFFF, 32'h0BAD_0BAD, CHK_DROP},
            '{1'b1, 16'h0008, 32'hC3C3_C3C3, CHK_MODEL},  // single in-order delivery
            '{1'b1, 16'h0010, 32'h3C3C_3C3C, CHK_ACK},    // top of moved window
            '{1'b1, 16'h0011, 32'h3C3C_3C3C, CHK_DROP}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            offer_packet(directed_rows[i].ok, directed_rows[i].seq,
                         directed_rows[i].pay, directed_rows[i].chk);

        // Random traffic, mostly within the receive window
        for (int k = 0; k < RANDOM_PACKETS; k++) begin
            idle_pct = (k >= 60 && k < 110) ? 0 : IDLE_PCT;
            pick = $urandom_range(99);
            if (pick < 60) begin
                seq = 16'(window_base + $urandom_range(WINDOW - 1));
                offer_packet(1'b1, seq, $urandom, CHK_MODEL);
            end else if (pick < 72) begin
                seq = 16'(window_base - $urandom_range(WINDOW, 1));
                offer_packet(1'b1, seq, $urandom, CHK_MODEL);
            end else if (pick < 86) begin
                offer_packet(1'($urandom), 16'($urandom), $urandom, CHK_MODEL);
            end else begin
                seq = 16'(window_base + $urandom_range(WINDOW - 1));
                offer_packet(1'b0, seq, $urandom, CHK_MODEL);
            end
        end
        idle_pct = IDLE_PCT;
        i_s_axis_tvalid = 1'b0;

        // Drain, then allow for a late burst
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * WINDOW + 8) @(posedge i_clk);

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/srr_pkg.sv
rtl/core/srr_slot_mem.sv
rtl/core/selective_repeat_receiver.sv
tb/selective_repeat_receiver_test.sv
